/* rtl/length_prefixed_record_store_core_macros.svh */
// assertion macros for the length-prefixed record store core
// no dependencies; taken in by files that carry concurrent checks
`ifndef LENGTH_PREFIXED_RECORD_STORE_CORE_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_STORE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define LPRS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LPRS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define LPRS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/lprs_pkg.sv */
// shared types, command and status codes for the record store core
// no dependencies
package lprs_pkg;

   localparam int STORE_BYTES = 1024;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   // a walk pointer can step one full record past the last header
   localparam int PTR_W       = $clog2(STORE_BYTES + 258);
   localparam int HDR_SIZE    = 2;

   localparam logic [7:0] MARK_ERASED = 8'hFF;
   localparam logic [7:0] MARK_LIVE   = 8'h00;

   localparam logic [2:0] CMD_CLEAR        = 3'd0;
   localparam logic [2:0] CMD_APPEND_BEGIN = 3'd1;
   localparam logic [2:0] CMD_APPEND_BYTE  = 3'd2;
   localparam logic [2:0] CMD_NEXT         = 3'd3;
   localparam logic [2:0] CMD_PREV         = 3'd4;
   localparam logic [2:0] CMD_GET_NTH      = 3'd5;
   localparam logic [2:0] CMD_READ_BYTE    = 3'd6;
   localparam logic [2:0] CMD_WRITE_BYTE   = 3'd7;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [7:0]        record_length;
      logic [7:0]        data_byte;
      logic [ADDR_W-1:0] live_rank;
      logic [ADDR_W-1:0] byte_address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] record_offset;
      logic [7:0]        record_length_out;
      logic [7:0]        read_data;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
      logic              clr_hdr;
   } mem_req_type;

endpackage

/* rtl/length_prefixed_record_store_core.sv */
// every accepted transaction gives one result through the output register; an append
// byte that closes the record makes four store writes, terminator first and header last,
// as does a zero-length append begin, which closes at once; chain walks read one header
// per step, and next and previous end with a read of the length byte at the cursor
// one transaction at a time; the record layout sets how many headers a walk reads
// synchronous reset; bytes 0 and 1 read as zero via two valid flops, no clearing pass
module length_prefixed_record_store_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lprs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lprs_pkg::rsp_type rsp_payload
);
   import lprs_pkg::*;

   `include "length_prefixed_record_store_core_macros.svh"

   mem_req_type mem_req;
   logic [7:0]  rd_a;
   logic [7:0]  rd_b;
   logic        res_valid;
   logic        res_ready;
   rsp_type     res;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   lprs_store_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   lprs_walk_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_req     (mem_req),
      .rd_a        (rd_a),
      .rd_b        (rd_b)
   );

   // output register frees the sequencer while a result waits
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `LPRS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
                    req_stall, "sequencer idle right after a transaction")
   `LPRS_ASSERT_IMP(a_rsp_from_ctrl, clock, reset, $rose(rsp_valid_ff),
                    $past(res_valid), "result appeared without sequencer result")
   `LPRS_ASSERT_IMP(a_not_found_zero, clock, reset,
                    rsp_valid_ff && rsp_ff.status == STATUS_NOT_FOUND,
                    rsp_ff.record_offset == '0 && rsp_ff.record_length_out == 8'h00,
                    "not found result carries a record")

endmodule

/* rtl/lprs_store_mem.sv */
// byte store: one write port, two registered read ports
// the first two bytes read as zero until written; uses lprs_pkg
module lprs_store_mem (
   input  logic                clock,
   input  logic                reset,
   input  lprs_pkg::mem_req_type mem_req,
   output logic [7:0]          rd_a,
   output logic [7:0]          rd_b
);
   import lprs_pkg::*;

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;
   logic       ok_a_ff;
   logic       ok_b_ff;
   logic [1:0] hdr_vld_ff;
   logic       hdr_a;
   logic       hdr_b;

   assign hdr_a = mem_req.raddr_a < ADDR_W'(HDR_SIZE);
   assign hdr_b = mem_req.raddr_b < ADDR_W'(HDR_SIZE);

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_a_ff <= mem[mem_req.raddr_a];
      rd_b_ff <= mem[mem_req.raddr_b];
      ok_a_ff <= !hdr_a || hdr_vld_ff[mem_req.raddr_a[0]];
      ok_b_ff <= !hdr_b || hdr_vld_ff[mem_req.raddr_b[0]];
   end

   // bytes 0 and 1 hold zero until their first write after reset or clear
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_vld_ff <= 2'b00;
      end else if (mem_req.clr_hdr) begin
         hdr_vld_ff <= 2'b00;
      end else if (mem_req.we && mem_req.waddr < ADDR_W'(HDR_SIZE)) begin
         hdr_vld_ff[mem_req.waddr[0]] <= 1'b1;
      end
   end

   assign rd_a = ok_a_ff ? rd_a_ff : 8'h00;
   assign rd_b = ok_b_ff ? rd_b_ff : 8'h00;

endmodule

/* rtl/lprs_walk_ctrl.sv */
// command sequencer: walks the header chain, runs appends and raw access
// drives the byte store through mem_req_type; uses lprs_pkg
module lprs_walk_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lprs_pkg::req_type     req_payload,
   output logic                  res_valid,
   input  logic                  res_ready,
   output lprs_pkg::rsp_type     res,
   output lprs_pkg::mem_req_type mem_req,
   input  logic [7:0]            rd_a,
   input  logic [7:0]            rd_b
);
   import lprs_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_HDR    = 3'd1;
   localparam logic [2:0] S_EVAL   = 3'd2;
   localparam logic [2:0] S_LEN_RD = 3'd3;
   localparam logic [2:0] S_LEN_EV = 3'd4;
   localparam logic [2:0] S_RAW    = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [7:0]        len_ff, len_in;
   logic [ADDR_W-1:0] nth_ff, nth_in;
   logic [PTR_W-1:0]  p_ff, p_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic              first_seen_ff, first_seen_in;
   logic              skip_ff, skip_in;
   logic              init_ff, init_in;
   logic [ADDR_W-1:0] app_base_ff, app_base_in;
   logic [7:0]        app_total_ff, app_total_in;
   logic [7:0]        app_count_ff, app_count_in;
   logic              app_active_ff, app_active_in;
   logic [1:0]        fin_ff, fin_in;
   rsp_type           res_ff, res_in;

   logic              accept;
   logic              in_range;
   logic              is_rec;
   logic              is_live;
   logic [PTR_W-1:0]  nxt;
   logic              no_fit;
   logic [ADDR_W-1:0] tail;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = state_ff != S_IDLE;
   assign res_valid = state_ff == S_DONE;
   assign res       = res_ff;

   assign in_range = ({1'b0, p_ff} + (PTR_W+1)'(HDR_SIZE)) <= (PTR_W+1)'(STORE_BYTES);
   assign is_rec   = in_range && (rd_a != 8'h00);
   assign is_live  = rd_b != MARK_ERASED;
   assign nxt      = p_ff + PTR_W'(rd_a) + PTR_W'(HDR_SIZE);
   assign no_fit   = ({2'b00, p_ff} + (PTR_W+2)'(len_ff) + (PTR_W+2)'(2 * HDR_SIZE))
                     > (PTR_W+2)'(STORE_BYTES);
   // first byte past the payload, where the terminator goes
   assign tail     = app_base_ff + ADDR_W'(app_total_ff) + ADDR_W'(HDR_SIZE);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      nth_in        = nth_ff;
      p_in          = p_ff;
      last_in       = last_ff;
      cursor_in     = cursor_ff;
      first_seen_in = first_seen_ff;
      skip_in       = skip_ff;
      init_in       = init_ff;
      app_base_in   = app_base_ff;
      app_total_in  = app_total_ff;
      app_count_in  = app_count_ff;
      app_active_in = app_active_ff;
      fin_in        = fin_ff;
      res_in        = res_ff;

      mem_req         = '0;
      mem_req.raddr_a = p_ff[ADDR_W-1:0];
      mem_req.raddr_b = p_ff[ADDR_W-1:0] + ADDR_W'(1);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in  = req_payload.cmd;
               len_in  = req_payload.record_length;
               nth_in  = req_payload.live_rank;
               res_in  = '0;
               p_in    = '0;
               last_in = '0;
               skip_in = 1'b0;
               init_in = 1'b0;
               case (req_payload.cmd)
                  CMD_CLEAR: begin
                     mem_req.clr_hdr = 1'b1;
                     app_active_in   = 1'b0;
                     state_in        = S_DONE;
                  end
                  CMD_APPEND_BEGIN: begin
                     state_in = S_HDR;
                  end
                  CMD_APPEND_BYTE: begin
                     state_in = S_DONE;
                     if (app_active_ff) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = app_base_ff + ADDR_W'(app_count_ff)
                                        + ADDR_W'(HDR_SIZE);
                        mem_req.wdata = req_payload.data_byte;
                        app_count_in  = app_count_ff + 8'd1;
                        res_in.record_offset     = app_base_ff;
                        res_in.record_length_out = app_total_ff;
                        if (({1'b0, app_count_ff} + 9'd1) >= {1'b0, app_total_ff}) begin
                           fin_in   = '0;
                           state_in = S_FIN;
                        end
                     end
                  end
                  CMD_NEXT: begin
                     if (!first_seen_ff) begin
                        cursor_in = '0;
                        init_in   = 1'b1;
                        state_in  = S_LEN_RD;
                     end else begin
                        p_in     = PTR_W'(cursor_ff);
                        skip_in  = 1'b1;
                        state_in = S_HDR;
                     end
                  end
                  CMD_PREV: begin
                     state_in = (cursor_ff == '0) ? S_LEN_RD : S_HDR;
                  end
                  CMD_GET_NTH: begin
                     state_in = S_HDR;
                  end
                  CMD_READ_BYTE: begin
                     mem_req.raddr_a = req_payload.byte_address;
                     state_in        = S_RAW;
                  end
                  default: begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = req_payload.byte_address;
                     mem_req.wdata = req_payload.data_byte;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_HDR: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_HDR;
            case (cmd_ff)
               CMD_APPEND_BEGIN: begin
                  if (is_rec) begin
                     p_in = nxt;
                  end else begin
                     res_in.record_offset     = p_ff[ADDR_W-1:0];
                     res_in.record_length_out = len_ff;
                     state_in                 = S_DONE;
                     if (no_fit) begin
                        res_in.status = STATUS_FULL;
                        app_active_in = 1'b0;
                     end else begin
                        app_base_in   = p_ff[ADDR_W-1:0];
                        app_total_in  = len_ff;
                        app_count_in  = '0;
                        app_active_in = 1'b1;
                        if (len_ff == 8'h00) begin
                           fin_in   = '0;
                           state_in = S_FIN;
                        end
                     end
                  end
               end
               CMD_NEXT: begin
                  if (skip_ff) begin
                     skip_in = 1'b0;
                     p_in    = nxt;
                  end else if (!is_rec) begin
                     cursor_in = '0;
                     state_in  = S_LEN_RD;
                  end else if (is_live) begin
                     cursor_in = p_ff[ADDR_W-1:0];
                     state_in  = S_LEN_RD;
                  end else begin
                     p_in = nxt;
                  end
               end
               CMD_PREV: begin
                  if (is_rec && (p_ff < PTR_W'(cursor_ff))) begin
                     if (is_live) begin
                        last_in = p_ff[ADDR_W-1:0];
                     end
                     p_in = nxt;
                  end else begin
                     cursor_in = last_ff;
                     state_in  = S_LEN_RD;
                  end
               end
               default: begin
                  // get nth: count down over live records
                  if (!is_rec) begin
                     res_in.status = STATUS_NOT_FOUND;
                     state_in      = S_DONE;
                  end else if (is_live && nth_ff == '0) begin
                     res_in.record_offset     = p_ff[ADDR_W-1:0];
                     res_in.record_length_out = rd_a;
                     state_in                 = S_DONE;
                  end else begin
                     if (is_live) begin
                        nth_in = nth_ff - ADDR_W'(1);
                     end
                     p_in = nxt;
                  end
               end
            endcase
         end
         S_LEN_RD: begin
            mem_req.raddr_a = cursor_ff;
            state_in        = S_LEN_EV;
         end
         S_LEN_EV: begin
            res_in.record_offset     = cursor_ff;
            res_in.record_length_out = rd_a;
            if (init_ff) begin
               first_seen_in = rd_a != 8'h00;
            end
            state_in = S_DONE;
         end
         S_RAW: begin
            res_in.read_data = rd_a;
            state_in         = S_DONE;
         end
         S_FIN: begin
            // terminator first, header last
            mem_req.we = 1'b1;
            fin_in     = fin_ff + 2'd1;
            case (fin_ff)
               2'd0: begin
                  mem_req.waddr = tail;
                  mem_req.wdata = 8'h00;
               end
               2'd1: begin
                  mem_req.waddr = tail + ADDR_W'(1);
                  mem_req.wdata = MARK_LIVE;
               end
               2'd2: begin
                  mem_req.waddr = app_base_ff;
                  mem_req.wdata = app_total_ff;
               end
               default: begin
                  mem_req.waddr = app_base_ff + ADDR_W'(1);
                  mem_req.wdata = MARK_LIVE;
                  app_active_in = 1'b0;
                  state_in      = S_DONE;
               end
            endcase
         end
         default: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_ff     <= '0;
         first_seen_ff <= 1'b0;
         app_base_ff   <= '0;
         app_total_ff  <= '0;
         app_count_ff  <= '0;
         app_active_ff <= 1'b0;
         skip_ff       <= 1'b0;
         init_ff       <= 1'b0;
         fin_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         first_seen_ff <= first_seen_in;
         app_base_ff   <= app_base_in;
         app_total_ff  <= app_total_in;
         app_count_ff  <= app_count_in;
         app_active_ff <= app_active_in;
         skip_ff       <= skip_in;
         init_ff       <= init_in;
         fin_ff        <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      len_ff  <= len_in;
      nth_ff  <= nth_in;
      p_ff    <= p_in;
      last_ff <= last_in;
      res_ff  <= res_in;
   end

endmodule

/* test/tb.sv */
// self-checking bench for length_prefixed_record_store_core: directed and random commands,
// in-bench shadow of the record chain, cursor and open append, answers checked in order
// depends on lprs_pkg and the core only
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lprs_pkg::*;

   localparam int STALL_LIMIT = 8000;
   localparam int CMD_TARGET = 1650;
   localparam logic [7:0] END_LEN = 8'h00;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;

   length_prefixed_record_store_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // shadow of the byte store and of the command state
   logic [7:0] store_img [STORE_BYTES];
   bit byte_known [STORE_BYTES];
   int unsigned cursor_pos, open_base, open_len, open_fill;
   bit cursor_primed, open_busy, stray_read, last_full;
   int unsigned heads[$];

   req_type pending_cmds[$];
   rsp_type pending_answers[$];
   rsp_type owed_answers[$];
   rsp_type offered_answer;
   rsp_type want;
   int planned, taken, answers_seen, mismatches, idle_cycles, hold_left;
   int full_count, miss_count, walk_count;
   bit held_once;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] peek_byte(int unsigned a);
      if (a >= STORE_BYTES) return 8'h00;
      if (!byte_known[a]) stray_read = 1'b1;
      return store_img[a];
   endfunction

   // writes are dropped once a command has touched a byte never written
   function automatic void poke_byte(int unsigned a, logic [7:0] v);
      if (a < STORE_BYTES && !stray_read) begin
         store_img[a] = v;
         byte_known[a] = 1'b1;
      end
   endfunction

   function automatic bit is_header(int unsigned a);
      if (a + HDR_SIZE > STORE_BYTES) return 1'b0;
      return peek_byte(a) != END_LEN;
   endfunction

   function automatic bit is_live(int unsigned a);
      return peek_byte(a + 1) != MARK_ERASED;
   endfunction

   function automatic int unsigned next_header(int unsigned a);
      return a + peek_byte(a) + HDR_SIZE;
   endfunction

   // terminator after the payload first, header last
   function automatic void close_record();
      poke_byte(open_base + HDR_SIZE + open_len, END_LEN);
      poke_byte(open_base + HDR_SIZE + open_len + 1, MARK_LIVE);
      poke_byte(open_base, open_len[7:0]);
      poke_byte(open_base + 1, MARK_LIVE);
      open_busy = 1'b0;
   endfunction

   function automatic rsp_type apply_cmd(req_type rq);
      rsp_type rs;
      int unsigned p, last_live, nth;
      rs = '0;
      case (rq.cmd)
         CMD_CLEAR: begin
            poke_byte(0, END_LEN);
            poke_byte(1, MARK_LIVE);
            open_busy = 1'b0;
         end
         CMD_APPEND_BEGIN: begin
            p = 0;
            while (is_header(p)) p = next_header(p);
            rs.record_offset = p[ADDR_W-1:0];
            rs.record_length_out = rq.record_length;
            if (p + rq.record_length + 2 * HDR_SIZE > STORE_BYTES) begin
               rs.status = STATUS_FULL;
               open_busy = 1'b0;
            end else begin
               open_base = p;
               open_len = 32'(rq.record_length);
               open_fill = 0;
               open_busy = 1'b1;
               if (open_len == 0) close_record();
            end
         end
         CMD_APPEND_BYTE: begin
            if (open_busy) begin
               poke_byte(open_base + HDR_SIZE + open_fill, rq.data_byte);
               open_fill++;
               rs.record_offset = open_base[ADDR_W-1:0];
               rs.record_length_out = open_len[7:0];
               if (open_fill >= open_len) close_record();
            end
         end
         CMD_NEXT: begin
            if (!cursor_primed) begin
               cursor_primed = peek_byte(0) != END_LEN;
               cursor_pos = 0;
            end else begin
               p = next_header(cursor_pos);
               while (1'b1) begin
                  if (!is_header(p)) begin
                     p = 0;
                     break;
                  end
                  if (is_live(p)) break;
                  p = next_header(p);
               end
               cursor_pos = p;
            end
            rs.record_offset = cursor_pos[ADDR_W-1:0];
            rs.record_length_out = peek_byte(cursor_pos);
         end
         CMD_PREV: begin
            if (cursor_pos != 0) begin
               p = 0;
               last_live = 0;
               while (p < cursor_pos && is_header(p)) begin
                  if (is_live(p)) last_live = p;
                  p = next_header(p);
               end
               cursor_pos = last_live;
            end
            rs.record_offset = cursor_pos[ADDR_W-1:0];
            rs.record_length_out = peek_byte(cursor_pos);
         end
         CMD_GET_NTH: begin
            p = 0;
            nth = 32'(rq.live_rank);
            rs.status = STATUS_NOT_FOUND;
            while (is_header(p)) begin
               if (is_live(p)) begin
                  if (nth == 0) begin
                     rs.status = STATUS_OK;
                     rs.record_offset = p[ADDR_W-1:0];
                     rs.record_length_out = peek_byte(p);
                     break;
                  end
                  nth--;
               end
               p = next_header(p);
            end
         end
         CMD_READ_BYTE: rs.read_data = peek_byte(32'(rq.byte_address));
         CMD_WRITE_BYTE: poke_byte(32'(rq.byte_address), rq.data_byte);
      endcase
      return rs;
   endfunction

   // queue a command with its answer; refused when it would read an unwritten byte
   function automatic bit post(req_type rq);
      rsp_type rs;
      int unsigned keep_cursor, keep_base, keep_len, keep_fill;
      bit keep_primed, keep_busy, counts;
      keep_cursor = cursor_pos;
      keep_base = open_base;
      keep_len = open_len;
      keep_fill = open_fill;
      keep_primed = cursor_primed;
      keep_busy = open_busy;
      counts = !(rq.cmd == CMD_APPEND_BYTE && !open_busy);
      stray_read = 1'b0;
      rs = apply_cmd(rq);
      if (stray_read) begin
         cursor_pos = keep_cursor;
         open_base = keep_base;
         open_len = keep_len;
         open_fill = keep_fill;
         cursor_primed = keep_primed;
         open_busy = keep_busy;
         return 1'b0;
      end
      pending_cmds.push_back(rq);
      pending_answers.push_back(rs);
      if (counts) planned++;
      if (rq.cmd inside {CMD_APPEND_BEGIN, CMD_NEXT, CMD_PREV, CMD_GET_NTH}) walk_count++;
      if (rs.status == STATUS_FULL) full_count++;
      if (rs.status == STATUS_NOT_FOUND) miss_count++;
      if (rq.cmd == CMD_APPEND_BEGIN) begin
         last_full = rs.status == STATUS_FULL;
         if (rs.status == STATUS_OK) heads.push_back(32'(rs.record_offset));
      end
      if (rq.cmd == CMD_CLEAR) begin
         heads.delete();
         last_full = 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [7:0] len, logic [7:0] dat,
                                        logic [ADDR_W-1:0] idx, logic [ADDR_W-1:0] adr);
      req_type rq;
      rq.cmd = op;
      rq.record_length = len;
      rq.data_byte = dat;
      rq.live_rank = idx;
      rq.byte_address = adr;
      return rq;
   endfunction

   function automatic req_type noise_req(logic [2:0] op);
      return make_req(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      ADDR_W'($urandom_range(STORE_BYTES - 1)),
                      ADDR_W'($urandom_range(STORE_BYTES - 1)));
   endfunction

   // mostly short records, a few long ones and some of the maximum length
   function automatic logic [7:0] pick_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return 8'($urandom_range(8));
      if (r < 95) return 8'($urandom_range(40, 9));
      if ($urandom_range(1) != 0) return 8'd255;
      return 8'($urandom_range(254, 41));
   endfunction

   function automatic bit post_append();
      req_type rq;
      int unsigned cut;
      rq = noise_req(CMD_APPEND_BEGIN);
      rq.record_length = pick_len();
      if (!post(rq)) return 1'b0;
      if (!open_busy) return 1'b1;
      // now and then the payload is cut short and left open
      cut = ($urandom_range(99) < 8) ? $urandom_range(open_len - 1) : open_len;
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(99) < 4)
            void'(post(noise_req(($urandom_range(1) != 0) ? CMD_NEXT : CMD_GET_NTH)));
         void'(post(noise_req(CMD_APPEND_BYTE)));
      end
      return 1'b1;
   endfunction

   function automatic bit random_op();
      req_type rq;
      int unsigned r, k;
      r = $urandom_range(999);
      if (last_full && $urandom_range(3) == 0) return post(noise_req(CMD_CLEAR));
      if (r < 240) return post_append();
      if (r < 380) return post(noise_req(CMD_NEXT));
      if (r < 480) return post(noise_req(CMD_PREV));
      rq = noise_req(CMD_GET_NTH);
      if (r < 600) begin
         if ($urandom_range(3) != 0)
            rq.live_rank = ADDR_W'($urandom_range(heads.size() + 1));
         return post(rq);
      end
      k = (heads.size() != 0) ? heads[$urandom_range(heads.size() - 1)] : 0;
      if (r < 700) begin
         rq.cmd = CMD_READ_BYTE;
         if ($urandom_range(1) != 0) rq.byte_address = ADDR_W'(k + $urandom_range(3));
         return post(rq);
      end
      rq.cmd = CMD_WRITE_BYTE;
      if (r < 770) begin
         // erase or revive a record through its mark byte
         rq.byte_address = ADDR_W'(k + 1);
         case ($urandom_range(5))
            0, 1, 2: rq.data_byte = MARK_ERASED;
            3, 4: rq.data_byte = MARK_LIVE;
            default: ;
         endcase
         return post(rq);
      end
      if (r < 810) begin
         // bend a length byte so walks land elsewhere or run off the store
         rq.byte_address = ADDR_W'(k);
         return post(rq);
      end
      if (r < 890) return post(rq);
      if (r < 920) return post(noise_req(CMD_APPEND_BYTE));
      if (r < 935) return post(noise_req(CMD_CLEAR));
      return post(noise_req(CMD_READ_BYTE));
   endfunction

   task automatic plan_random(int goal);
      int tries;
      while (planned < goal) begin
         tries = 0;
         while (!random_op() && tries < 20) tries++;
         if (tries == 20) void'(post(noise_req(CMD_CLEAR)));
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || owed_answers.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_miss(string what, rsp_type exp_rsp, rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t mismatch, %s", $realtime, what);
         $display("   expected status %0d offset %0d length %0d data %02h", exp_rsp.status,
                  exp_rsp.record_offset, exp_rsp.record_length_out, exp_rsp.read_data);
         $display("   actual   status %0d offset %0d length %0d data %02h", got.status,
                  got.record_offset, got.record_length_out, got.read_data);
      end
   endtask

   initial begin
      foreach (store_img[i]) begin
         store_img[i] = 8'h00;
         byte_known[i] = i < HDR_SIZE;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty store, first cursor step, zero-length and replaced appends
      void'(post(make_req(CMD_NEXT, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_PREV, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_GET_NTH, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_READ_BYTE, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BEGIN, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BYTE, 8'd0, 8'hFF, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BEGIN, 8'd3, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BYTE, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BYTE, 8'd0, 8'hFF, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BYTE, 8'd0, 8'h7E, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BEGIN, 8'd2, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BYTE, 8'd0, 8'h01, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BEGIN, 8'd1, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_APPEND_BYTE, 8'd0, 8'h5A, 10'd0, 10'd0)));
      void'(post(make_req(CMD_NEXT, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_NEXT, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_NEXT, 8'd0, 8'h00, 10'd0, 10'd0)));
      // erase the first record, then step and search around it
      void'(post(make_req(CMD_WRITE_BYTE, 8'd0, MARK_ERASED, 10'd0, 10'd1)));
      void'(post(make_req(CMD_GET_NTH, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_NEXT, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_PREV, 8'd0, 8'h00, 10'd0, 10'd0)));
      void'(post(make_req(CMD_GET_NTH, 8'd0, 8'h00, 10'd1023, 10'd0)));
      void'(post(make_req(CMD_WRITE_BYTE, 8'd255, 8'hA5, 10'd0, 10'd1023)));
      void'(post(make_req(CMD_READ_BYTE, 8'd0, 8'h00, 10'd0, 10'd1023)));
      void'(post(make_req(CMD_CLEAR, 8'd0, 8'h00, 10'd0, 10'd0)));
      wait_drained();

      plan_random(CMD_TARGET / 2);
      wait_drained();
      plan_random(CMD_TARGET);
      wait_drained();
      repeat (40) @(posedge clock);

      $display("summary: %0d commands sent, %0d answers checked, %0d mismatches",
               taken, answers_seen, mismatches);
      $display("summary: %0d chain walks, %0d store full, %0d record not found",
               walk_count, full_count, miss_count);
      if (mismatches == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   // sender: holds a stalled transaction, idles at random outside a quiet stretch
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            owed_answers.push_back(offered_answer);
            taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 &&
                ((taken >= 700 && taken < 1000) || $urandom_range(99) >= 23)) begin
               req_payload <= pending_cmds.pop_front();
               offered_answer = pending_answers.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each answer, stalls at random and once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (owed_answers.size() == 0) begin
               report_miss("answer with no command outstanding", '0, rsp_payload);
            end else begin
               want = owed_answers.pop_front();
               if (rsp_payload.status !== want.status ||
                   rsp_payload.record_offset !== want.record_offset ||
                   rsp_payload.record_length_out !== want.record_length_out ||
                   rsp_payload.read_data !== want.read_data)
                  report_miss("wrong answer field", want, rsp_payload);
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!held_once && answers_seen >= 400) begin
            held_once = 1'b1;
            hold_left = 299;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (answers_seen < 700 || answers_seen >= 1000) &&
                         $urandom_range(99) < 23;
         end
      end
   end

   // watchdog: counts cycles with work outstanding and no transaction on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (!req_valid && owed_answers.size() == 0))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
            $display("tb: errors");
            $finish;
         end
      end
   end

endmodule
